// ----- rtl/core/brbc_pkg.sv -----
// ----------------------------------------------------------------------------
// brbc_pkg
// Shared types and codes for the block reference bitmap checker.
// ----------------------------------------------------------------------------
package brbc_pkg;

	localparam int BLK_W  = 17;
	localparam int CFG_W  = 17;
	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;

	// Command codes
	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_MARK   = 2'd1,
		CMD_EXTENT = 2'd2,
		CMD_FINAL  = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_RANGE   = 3'd1,
		ST_DUP     = 3'd2,
		ST_MISSING = 3'd3,
		ST_REFUSED = 3'd4
	} status_t;

	// Configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_TOTAL    = 1'b0;
	localparam cfg_idx_t CFG_RESERVED = 1'b1;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] block_number;
		logic [31:0] extent_length;
	} cmd_item_t;

	typedef struct packed {
		status_t          status;
		logic [BLK_W-1:0] first_block;
		logic             faulted;
	} rsp_item_t;

	// Request to the word unit: one map word and an inclusive bit range
	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [BIT_W-1:0]  lo;
		logic [BIT_W-1:0]  hi;
		logic              find_zero;
	} word_req_t;

	// Answer from the word unit
	typedef struct packed {
		logic [WORD_W-1:0] mask;
		logic              hit;
		logic [BIT_W-1:0]  idx;
	} word_rsp_t;

endpackage

// ----- rtl/core/brbc_ram.sv -----
// ----------------------------------------------------------------------------
// brbc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module brbc_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/brbc_word_unit.sv -----
// ----------------------------------------------------------------------------
// brbc_word_unit
// Shared word unit: builds the range mask for one map word and finds the
// lowest set (or clear) bit inside that range.
// ----------------------------------------------------------------------------
module brbc_word_unit
	import brbc_pkg::*;
(
	input  word_req_t req,
	output word_rsp_t rsp
);

	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] cand;

	// Inclusive range mask lo..hi
	assign mask = ({WORD_W{1'b1}} << req.lo) & ({WORD_W{1'b1}} >> (6'd63 - req.hi));
	assign cand = (req.find_zero ? ~req.data : req.data) & mask;

	// Lowest candidate bit
	always_comb begin
		rsp.mask = mask;
		rsp.hit  = |cand;
		rsp.idx  = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				rsp.idx = BIT_W'(b);
			end
		end
	end

endmodule

// ----- rtl/core/block_reference_bitmap_checker.sv -----
// ----------------------------------------------------------------------------
// block_reference_bitmap_checker
// Each command passes decode, a read state, the work state for each map word
// touched (mark: 1, extent: words spanned, start: ceil(total/64), final: words
// up to the first unmarked block) and a done state; commands that touch no word
// (refused, out of range, block zero, empty extent, final on an empty map) go
// from decode to done. One command in flight; result stalls hold the done state.
// Reset clears control state and the fault flag; a start rewrites every word
// that later commands can read, so the map needs no clearing pass.
// ----------------------------------------------------------------------------
module block_reference_bitmap_checker
	import brbc_pkg::*;
#(
	parameter int MAX_BLOCKS = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_item_t        cmd_item,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_item_t        rsp_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_WORK,
		S_DONE
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [31:0]      nr_q;
	logic [31:0]      len_q;
	logic [CFG_W-1:0] total_q;
	logic [CFG_W-1:0] reserved_q;
	logic [BLK_W-1:0] map_size_q;
	logic [BLK_W-1:0] res_q;
	logic [BLK_W-1:0] first_blk_q;
	logic [BLK_W-1:0] last_blk_q;
	logic [BLK_W-1:0] hit_blk_q;
	logic [AW-1:0]    cur_q;
	logic             found_q;
	logic             fault_q;
	status_t          status_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_item_q;

	logic [32:0]       ext_end;
	logic [31:0]       ms_ext;
	logic [AW-1:0]     first_wd;
	logic [AW-1:0]     last_wd;
	logic [AW-1:0]     res_wd;
	logic              last_word;
	logic [BLK_W-1:0]  cur_blk;
	logic [WORD_W-1:0] start_word;
	logic              ram_we;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	word_req_t         wreq;
	word_rsp_t         wrsp;

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			reserved_q <= CFG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TOTAL:    total_q    <= cfg_data;
				CFG_RESERVED: reserved_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Range checks and word positions
	assign ext_end   = {1'b0, nr_q} + {1'b0, len_q};
	assign ms_ext    = {15'd0, map_size_q};
	assign first_wd  = AW'(first_blk_q >> BIT_W);
	assign last_wd   = AW'(last_blk_q >> BIT_W);
	assign res_wd    = AW'(res_q >> BIT_W);
	assign last_word = (cur_q == last_wd);
	assign cur_blk   = BLK_W'({cur_q, wrsp.idx});

	// Word unit request
	always_comb begin
		wreq.data      = ram_rdata;
		wreq.find_zero = (cmd_q == CMD_FINAL);
		if (cmd_q == CMD_START) begin
			wreq.lo = '0;
			wreq.hi = res_q[BIT_W-1:0] - 6'd1;
		end else begin
			wreq.lo = (cur_q == first_wd) ? first_blk_q[BIT_W-1:0] : '0;
			wreq.hi = last_word ? last_blk_q[BIT_W-1:0] : 6'd63;
		end
	end

	brbc_word_unit u_word (
		.req (wreq),
		.rsp (wrsp)
	);

	// Reserved pattern for one word at start
	always_comb begin
		if (cur_q < res_wd) begin
			start_word = {WORD_W{1'b1}};
		end else if (cur_q == res_wd && res_q[BIT_W-1:0] != '0) begin
			start_word = wrsp.mask;
		end else begin
			start_word = '0;
		end
	end

	// Map RAM access
	assign ram_we    = (state_q == S_WORK) && (cmd_q != CMD_FINAL);
	assign ram_wdata = (cmd_q == CMD_START) ? start_word : (ram_rdata | wrsp.mask);
	assign ram_raddr = (state_q == S_WORK) ? (cur_q + AW'(1)) : cur_q;

	brbc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NWORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_START;
			fault_q     <= 1'b0;
			found_q     <= 1'b0;
			status_q    <= ST_OK;
			map_size_q  <= '0;
			rsp_valid_q <= 1'b0;
			cur_q       <= '0;
		end else begin
			// Result transfer; a new result in S_DONE takes its place
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd_item.cmd;
						nr_q    <= cmd_item.block_number;
						len_q   <= cmd_item.extent_length;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					hit_blk_q <= '0;
					found_q   <= 1'b0;
					status_q  <= ST_OK;
					state_q   <= S_DONE;
					unique case (cmd_q)
						CMD_START: begin
							if (fault_q) begin
								status_q <= ST_REFUSED;
							end else if (total_q <= reserved_q ||
									{15'd0, total_q} > 32'(MAX_BLOCKS)) begin
								status_q <= ST_REFUSED;
								fault_q  <= 1'b1;
							end else begin
								map_size_q  <= total_q;
								res_q       <= reserved_q;
								first_blk_q <= '0;
								last_blk_q  <= total_q - BLK_W'(1);
								cur_q       <= '0;
								state_q     <= S_READ;
							end
						end
						CMD_MARK: begin
							if (nr_q == '0) begin
								status_q <= ST_OK;
							end else if (nr_q >= ms_ext) begin
								status_q <= ST_RANGE;
								fault_q  <= 1'b1;
							end else begin
								first_blk_q <= nr_q[BLK_W-1:0];
								last_blk_q  <= nr_q[BLK_W-1:0];
								cur_q       <= AW'(nr_q[BLK_W-1:0] >> BIT_W);
								state_q     <= S_READ;
							end
						end
						CMD_EXTENT: begin
							if (nr_q >= ms_ext || len_q > ms_ext ||
									ext_end > {1'b0, ms_ext}) begin
								status_q <= ST_RANGE;
								fault_q  <= 1'b1;
							end else if (len_q == '0) begin
								status_q <= ST_OK;
							end else begin
								first_blk_q <= nr_q[BLK_W-1:0];
								last_blk_q  <= ext_end[BLK_W-1:0] - BLK_W'(1);
								cur_q       <= AW'(nr_q[BLK_W-1:0] >> BIT_W);
								state_q     <= S_READ;
							end
						end
						CMD_FINAL: begin
							if (map_size_q != '0) begin
								first_blk_q <= '0;
								last_blk_q  <= map_size_q - BLK_W'(1);
								cur_q       <= '0;
								state_q     <= S_READ;
							end
						end
						default: ;
					endcase
				end
				S_READ: begin
					state_q <= S_WORK;
				end
				S_WORK: begin
					cur_q <= cur_q + AW'(1);
					unique case (cmd_q)
						CMD_START: begin
							if (last_word) begin
								state_q <= S_DONE;
							end
						end
						CMD_FINAL: begin
							if (wrsp.hit) begin
								hit_blk_q <= cur_blk;
								status_q  <= ST_MISSING;
								fault_q   <= 1'b1;
								state_q   <= S_DONE;
							end else if (last_word) begin
								state_q <= S_DONE;
							end
						end
						default: begin
							if (wrsp.hit && !found_q) begin
								found_q   <= 1'b1;
								hit_blk_q <= cur_blk;
							end
							if (last_word) begin
								if (found_q || wrsp.hit) begin
									status_q <= ST_DUP;
									fault_q  <= 1'b1;
								end
								state_q <= S_DONE;
							end
						end
					endcase
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q            <= 1'b1;
						rsp_item_q.status      <= status_q;
						rsp_item_q.first_block <= hit_blk_q;
						rsp_item_q.faulted     <= fault_q;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/brbc_checker.sv -----
// ----------------------------------------------------------------------------
// brbc_checker
// Port level checks for the block reference bitmap checker, bound to the
// top level.
// ----------------------------------------------------------------------------
module brbc_checker
	import brbc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp_item
);

	logic seen_fault_q;

	// Remember a faulted result once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_fault_q <= 1'b0;
		end else if (rsp_valid && !rsp_stall && rsp_item.faulted) begin
			seen_fault_q <= 1'b1;
		end
	end

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("result changed while stalled");

	// Fault flag is sticky across results
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_fault_q |-> rsp_item.faulted)
		else $error("fault flag dropped");

	// Any non-ok status comes with the fault flag
	a_fault_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.status != ST_OK |-> rsp_item.faulted)
		else $error("bad status without fault");

	// Block field only carries a value for conflicts and missing blocks
	a_blk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_item.status == ST_OK || rsp_item.status == ST_RANGE ||
			rsp_item.status == ST_REFUSED) |-> rsp_item.first_block == '0)
		else $error("first_block set without a reported block");

	// One command at a time
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second command taken while busy");

endmodule

bind block_reference_bitmap_checker brbc_checker u_brbc_checker (.*);
